### rtl/core/min_heap_priority_queue_core_macros.svh
// Assertion helpers for the heap datapath.
`ifndef MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH

// Checked on every clock edge outside of reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MHPQ_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/mhpq_pkg.sv
package mhpq_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int PW          = $clog2(CAPACITY);
  localparam int CW          = PW + 1;
  localparam int MAX_SWAPS   = 63;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [PW-1:0] pos_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_HEAPIFY = 3'd1,
    OP_INSERT  = 3'd2,
    OP_EXTRACT = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RD_ZERO, RD_POS, RD_LAST, RD_HEAP, RD_PARENT, RD_LEFT, RD_RIGHT
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_APPEND, WR_CUR, WR_PARENT, WR_BEST
  } wr_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_APPEND, ST_XTOP, ST_XLAST, ST_XCUR, ST_RPOS, ST_RTAKE,
    ST_RCUR, ST_HSTEP, ST_HCUR, ST_SU_CHK, ST_SU_CMP, ST_SU_WR, ST_SD_CHK,
    ST_SD_LEFT, ST_SD_RIGHT, ST_SD_MOVE, ST_SD_WR, ST_EMIT
  } state_e;

  typedef struct packed {
    logic    accept;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    append;
    logic    take_res;
    logic    take_cur;
    logic    dec_cnt;
    logic    set_i_pos;
    logic    set_i_zero;
    logic    i_parent;
    logic    i_best;
    logic    heap_init;
    logic    heap_step;
    logic    take_left;
    logic    take_right;
    logic    emit_swap;
    logic    emit_final;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic err_ok;
    logic cnt_ge2;
    logic i_zero;
    logic cur_lt_rd;
    logic l_ok;
    logic r_ok;
    logic best_is_i;
    logic hi_zero;
    logic pos_in;
    logic report_ok;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/mhpq_datapath.sv
`include "min_heap_priority_queue_core_macros.svh"

module mhpq_datapath
  import mhpq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  input  logic [2:0] in_op_i,
  input  val_t     in_value_i,
  input  pos_t     in_pos_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output val_t     out_value_o,
  output status_e  out_status_o,
  output logic     out_swap_o,
  output pos_t     out_upper_o,
  output pos_t     out_lower_o,
  output cnt_t     out_total_o,
  output logic     out_last_o
);

  val_t    mem [CAPACITY];
  val_t    rd_q;
  op_e     op_q;
  val_t    cur_q, res_q, best_val_q;
  pos_t    pos_q, i_q, hi_q, best_idx_q;
  cnt_t    cnt_q;
  status_e stat_q;
  logic [5:0] k_q;
  logic    out_valid_q;
  val_t    out_value_q;
  status_e out_status_q;
  logic    out_swap_q, out_last_q;
  pos_t    out_upper_q, out_lower_q;
  cnt_t    out_total_q;

  status_e in_stat;
  cnt_t    l_idx;
  logic [CW:0] r_idx;
  pos_t    parent, rd_addr, wr_addr;
  val_t    wr_data;
  logic    out_free;
  cnt_t    cnt_m1;

  assign l_idx  = {i_q, 1'b1};
  assign r_idx  = {1'b0, i_q, 1'b0} + (CW+1)'(2);
  assign parent = (i_q - PW'(1)) >> 1;
  assign cnt_m1 = cnt_q - CW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  // Error status of an incoming operation against the current fill level.
  always_comb begin
    in_stat = STAT_OK;
    case (op_e'(in_op_i))
      OP_APPEND, OP_INSERT: begin
        if (cnt_q == CW'(CAPACITY)) in_stat = STAT_FULL;
      end
      OP_EXTRACT: begin
        if (cnt_q == '0) in_stat = STAT_EMPTY;
      end
      OP_REMOVE, OP_READ: begin
        if (cnt_q == '0) in_stat = STAT_EMPTY;
        else if ({1'b0, in_pos_i} >= cnt_q) in_stat = STAT_RANGE;
      end
      default: in_stat = STAT_OK;
    endcase
  end

  // Read address select.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO:   rd_addr = '0;
      RD_POS:    rd_addr = pos_q;
      RD_LAST:   rd_addr = cnt_m1[PW-1:0];
      RD_HEAP:   rd_addr = hi_q - PW'(1);
      RD_PARENT: rd_addr = parent;
      RD_LEFT:   rd_addr = l_idx[PW-1:0];
      RD_RIGHT:  rd_addr = r_idx[PW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  // Write address and data select.
  always_comb begin
    wr_addr = i_q;
    wr_data = cur_q;
    case (cmd_i.wr_sel)
      WR_APPEND: wr_addr = cnt_q[PW-1:0];
      WR_PARENT: wr_data = rd_q;
      WR_BEST:   wr_data = best_val_q;
      default:   wr_data = cur_q;
    endcase
  end

  // Heap storage with one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sel != WR_NONE) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // Control registers of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.append) cnt_q <= cnt_q + CW'(1);
      else if (cmd_i.dec_cnt) cnt_q <= cnt_m1;
      if (cmd_i.emit_swap || cmd_i.emit_final) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(in_op_i);
      cur_q  <= in_value_i;
      pos_q  <= in_pos_i;
      stat_q <= in_stat;
      res_q  <= '0;
      k_q    <= '0;
    end
    if (cmd_i.take_res) res_q <= rd_q;
    if (cmd_i.take_cur) cur_q <= rd_q;
    if (cmd_i.append) i_q <= cnt_q[PW-1:0];
    if (cmd_i.set_i_pos) i_q <= pos_q;
    if (cmd_i.set_i_zero) i_q <= '0;
    if (cmd_i.i_parent) i_q <= parent;
    if (cmd_i.i_best) i_q <= best_idx_q;
    if (cmd_i.heap_init) hi_q <= cnt_q[CW-1:1];
    if (cmd_i.heap_step) begin
      hi_q <= hi_q - PW'(1);
      i_q  <= hi_q - PW'(1);
    end
    if (cmd_i.take_left) begin
      if (rd_q < cur_q) begin
        best_idx_q <= l_idx[PW-1:0];
        best_val_q <= rd_q;
      end else begin
        best_idx_q <= i_q;
        best_val_q <= cur_q;
      end
    end
    if (cmd_i.take_right && (rd_q < best_val_q)) begin
      best_idx_q <= r_idx[PW-1:0];
      best_val_q <= rd_q;
    end
    if (cmd_i.emit_swap) k_q <= k_q + 6'd1;
  end

  // Output register toward the result channel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_swap) begin
      out_value_q  <= '0;
      out_status_q <= STAT_OK;
      out_swap_q   <= 1'b1;
      out_upper_q  <= i_q;
      out_lower_q  <= best_idx_q;
      out_total_q  <= cnt_q;
      out_last_q   <= 1'b0;
    end else if (cmd_i.emit_final) begin
      out_value_q  <= res_q;
      out_status_q <= stat_q;
      out_swap_q   <= 1'b0;
      out_upper_q  <= '0;
      out_lower_q  <= '0;
      out_total_q  <= cnt_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_swap_o   = out_swap_q;
  assign out_upper_o  = out_upper_q;
  assign out_lower_o  = out_lower_q;
  assign out_total_o  = out_total_q;
  assign out_last_o   = out_last_q;

  // Status toward the controller.
  always_comb begin
    stat_o.op        = op_q;
    stat_o.err_ok    = (stat_q == STAT_OK);
    stat_o.cnt_ge2   = (cnt_q >= CW'(2));
    stat_o.i_zero    = (i_q == '0);
    stat_o.cur_lt_rd = (cur_q < rd_q);
    stat_o.l_ok      = (l_idx < cnt_q);
    stat_o.r_ok      = (r_idx < {1'b0, cnt_q});
    stat_o.best_is_i = (best_idx_q == i_q);
    stat_o.hi_zero   = (hi_q == '0);
    stat_o.pos_in    = ({1'b0, pos_q} < cnt_q);
    stat_o.report_ok = (k_q != 6'(MAX_SWAPS));
    stat_o.out_free  = out_free;
  end

  `MHPQ_ASSERT(a_cnt_max, cnt_q <= CW'(CAPACITY), "entry count above capacity")
  `MHPQ_ASSERT(a_emit_free, (cmd_i.emit_swap || cmd_i.emit_final) |-> out_free, "result overwritten")
  `MHPQ_ASSERT(a_append_cnt, cmd_i.append |=> cnt_q == $past(cnt_q) + CW'(1), "append miscounted")
  `MHPQ_ASSERT_NR(a_rst_out, !rst_ni |=> !out_valid_q, "result valid out of reset")

endmodule

### rtl/core/mhpq_controller.sv
module mhpq_controller
  import mhpq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    first_d = first_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DISP;
      ST_DISP: begin
        if (!stat_i.err_ok) state_d = ST_EMIT;
        else begin
          case (stat_i.op)
            OP_APPEND, OP_INSERT: state_d = ST_APPEND;
            OP_HEAPIFY: state_d = stat_i.cnt_ge2 ? ST_HSTEP : ST_EMIT;
            OP_EXTRACT: state_d = ST_XTOP;
            OP_REMOVE, OP_READ: state_d = ST_RPOS;
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_APPEND: begin
        first_d = 1'b0;
        state_d = (stat_i.op == OP_INSERT) ? ST_SU_CHK : ST_EMIT;
      end
      ST_XTOP:  state_d = ST_XLAST;
      ST_XLAST: state_d = ST_XCUR;
      ST_XCUR:  state_d = ST_SD_CHK;
      ST_RPOS:  state_d = ST_RTAKE;
      ST_RTAKE: state_d = (stat_i.op == OP_REMOVE) ? ST_RCUR : ST_EMIT;
      ST_RCUR: begin
        if (stat_i.pos_in) begin
          first_d = 1'b1;
          state_d = ST_SU_CHK;
        end else state_d = ST_EMIT;
      end
      ST_SU_CHK: begin
        if (stat_i.i_zero) state_d = first_q ? ST_SD_CHK : ST_SU_WR;
        else state_d = ST_SU_CMP;
      end
      ST_SU_CMP: begin
        if (stat_i.cur_lt_rd) begin
          first_d = 1'b0;
          state_d = ST_SU_CHK;
        end else state_d = first_q ? ST_SD_CHK : ST_SU_WR;
      end
      ST_SU_WR:  state_d = ST_EMIT;
      ST_SD_CHK: state_d = stat_i.l_ok ? ST_SD_LEFT : ST_SD_WR;
      ST_SD_LEFT: state_d = stat_i.r_ok ? ST_SD_RIGHT : ST_SD_MOVE;
      ST_SD_RIGHT: state_d = ST_SD_MOVE;
      ST_SD_MOVE: begin
        if (stat_i.best_is_i) state_d = ST_SD_WR;
        else if (stat_i.op != OP_HEAPIFY || !stat_i.report_ok || stat_i.out_free)
          state_d = ST_SD_CHK;
      end
      ST_SD_WR: begin
        if (stat_i.op == OP_HEAPIFY && !stat_i.hi_zero) state_d = ST_HSTEP;
        else state_d = ST_EMIT;
      end
      ST_HSTEP: state_d = ST_HCUR;
      ST_HCUR:  state_d = ST_SD_CHK;
      ST_EMIT:  if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_ZERO;
    cmd_o.wr_sel = WR_NONE;
    case (state_q)
      ST_IDLE: cmd_o.accept = in_valid_i;
      ST_DISP: cmd_o.heap_init = 1'b1;
      ST_APPEND: begin
        cmd_o.wr_sel = WR_APPEND;
        cmd_o.append = 1'b1;
      end
      ST_XTOP: cmd_o.rd_sel = RD_ZERO;
      ST_XLAST: begin
        cmd_o.take_res   = 1'b1;
        cmd_o.rd_sel     = RD_LAST;
        cmd_o.dec_cnt    = 1'b1;
        cmd_o.set_i_zero = 1'b1;
      end
      ST_XCUR: cmd_o.take_cur = 1'b1;
      ST_RPOS: cmd_o.rd_sel = RD_POS;
      ST_RTAKE: begin
        cmd_o.take_res = 1'b1;
        if (stat_i.op == OP_REMOVE) begin
          cmd_o.dec_cnt   = 1'b1;
          cmd_o.set_i_pos = 1'b1;
          cmd_o.rd_sel    = RD_LAST;
        end
      end
      ST_RCUR: cmd_o.take_cur = stat_i.pos_in;
      ST_SU_CHK: cmd_o.rd_sel = RD_PARENT;
      ST_SU_CMP: begin
        if (stat_i.cur_lt_rd) begin
          cmd_o.wr_sel   = WR_PARENT;
          cmd_o.i_parent = 1'b1;
        end
      end
      ST_SU_WR:  cmd_o.wr_sel = WR_CUR;
      ST_SD_CHK: cmd_o.rd_sel = RD_LEFT;
      ST_SD_LEFT: begin
        cmd_o.take_left = 1'b1;
        cmd_o.rd_sel    = RD_RIGHT;
      end
      ST_SD_RIGHT: cmd_o.take_right = 1'b1;
      ST_SD_MOVE: begin
        if (!stat_i.best_is_i) begin
          if (stat_i.op == OP_HEAPIFY && stat_i.report_ok) begin
            if (stat_i.out_free) begin
              cmd_o.wr_sel    = WR_BEST;
              cmd_o.i_best    = 1'b1;
              cmd_o.emit_swap = 1'b1;
            end
          end else begin
            cmd_o.wr_sel = WR_BEST;
            cmd_o.i_best = 1'b1;
          end
        end
      end
      ST_SD_WR: cmd_o.wr_sel = WR_CUR;
      ST_HSTEP: begin
        cmd_o.heap_step = 1'b1;
        cmd_o.rd_sel    = RD_HEAP;
      end
      ST_HCUR: cmd_o.take_cur = 1'b1;
      ST_EMIT: cmd_o.emit_final = stat_i.out_free;
      default: cmd_o.accept = 1'b0;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

### rtl/core/min_heap_priority_queue_core.sv
// Binary min-heap of signed 32-bit values, 64 entries deep.
// The operation transfer arrives on the s_axis channel: tuser carries the
// opcode, tdata the value and the position. Results leave on m_axis, one
// transfer per item; tlast marks the final item of an operation and tuser
// flags a heapify swap report.
// Only one operation is in flight; s_axis_tready_o is high while the
// sequencer is idle. Insert, extract and remove walk the tree one level
// at a time through the registered read of the heap memory. Heapify runs
// a sift-down for every parent and emits one transfer for each of its
// first 63 swaps; later swaps are made but not reported. A stalled
// receiver holds the output register; the sequencer waits at the next
// result until it is taken. Reset empties the heap at once; memory
// contents are not cleared, and entries at or above the fill level are
// never used.
module min_heap_priority_queue_core
  import mhpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // item_value[31:0], position[37:32]
  input  logic [2:0]  s_axis_tuser_i,   // opcode[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_value[31:0], status[33:32], swap_upper[39:34], swap_lower[45:40],
  // entry_total[52:46]
  output logic [55:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o,   // is_swap[0]
  output logic        m_axis_tlast_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  val_t     out_value;
  status_e  out_status;
  logic     out_swap, out_last;
  pos_t     out_upper, out_lower;
  cnt_t     out_total;

  mhpq_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mhpq_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_op_i      (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i[31:0]),
    .in_pos_i     (s_axis_tdata_i[37:32]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (out_value),
    .out_status_o (out_status),
    .out_swap_o   (out_swap),
    .out_upper_o  (out_upper),
    .out_lower_o  (out_lower),
    .out_total_o  (out_total),
    .out_last_o   (out_last)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = {3'b000, out_total, out_lower, out_upper, out_status, out_value};
  assign m_axis_tuser_o = out_swap;
  assign m_axis_tlast_o = out_last;

endmodule
